// File: rtl/spi_mrb_pkg.sv
package spi_mrb_pkg;

  // register map, byte offsets
  localparam logic [11:0] ADDR_VERSION   = 12'h000;
  localparam logic [11:0] ADDR_IPCFG     = 12'h004;
  localparam logic [11:0] ADDR_SRST      = 12'h010;
  localparam logic [11:0] ADDR_SCRATCH   = 12'h01C;
  localparam logic [11:0] ADDR_INT_STAT  = 12'h020;
  localparam logic [11:0] ADDR_INT_EN    = 12'h024;
  localparam logic [11:0] ADDR_XFER_CTRL = 12'h100;
  localparam logic [11:0] ADDR_TIMING    = 12'h104;
  localparam logic [11:0] ADDR_MODE      = 12'h108;
  localparam logic [11:0] ADDR_TXDATA    = 12'h200;
  localparam logic [11:0] ADDR_RXDATA    = 12'h300;

  localparam logic [31:0] VERSION_WORD = 32'h0001_0000;
  localparam logic [4:0]  NUM_BUF     = 5'd1;
  localparam int          INT_COMPLETE = 0;
  localparam int          CTRL_START   = 0;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    logic [31:0] miso;
    logic [31:0] wdata;
    logic [11:0] addr;
    op_t         op;
  } item_t;

  // first member lands in the top bits, so read data sits lowest
  typedef struct packed {
    logic [5:0]  frame_bits;
    logic [31:0] mosi;
    logic        xfer_valid;
    logic [31:0] cs;
    logic        irq;
    logic [31:0] rdata;
  } result_t;

  typedef struct packed {
    logic [3:0] hold;
    logic [3:0] setup;
    logic       pha;
    logic       pol;
    logic [7:0] div;
  } timing_t;

  localparam timing_t TIMING_RESET = '{hold: 4'd1, setup: 4'd1, pha: 1'b1, pol: 1'b1,
                                       div: 8'd1};

endpackage

// File: rtl/spi_mrb_order.sv
module spi_mrb_order (
  input  logic        order_sel,
  input  logic [4:0]  len_m1,
  input  logic [31:0] tx_word,
  input  logic [31:0] miso,
  output logic [31:0] mosi,
  output logic [31:0] rx_word
);

  logic [4:0]  shamt;
  logic [31:0] mask;
  logic [31:0] tx_swap;
  logic [31:0] tx_rev;
  logic [31:0] rx_shift;
  logic [31:0] rx_rev;
  logic [31:0] rx_swap;

  // 32 - frame length
  assign shamt = ~len_m1;
  assign mask  = 32'hFFFF_FFFF >> shamt;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      // msb-first within each byte
      tx_swap[i] = tx_word[i ^ 7];
    end
    for (int i = 0; i < 32; i++) begin
      tx_rev[i] = tx_swap[31 - i];
    end
    rx_shift = miso << shamt;
    for (int i = 0; i < 32; i++) begin
      rx_rev[i] = rx_shift[31 - i];
    end
    for (int i = 0; i < 32; i++) begin
      rx_swap[i] = rx_rev[i ^ 7];
    end
  end

  assign mosi    = order_sel ? (tx_word & mask) : (tx_rev >> shamt);
  assign rx_word = order_sel ? (miso & mask) : rx_swap;

endmodule

// File: rtl/spi_mrb_regs.sv
module spi_mrb_regs #(
  parameter int NUM_CS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  spi_mrb_pkg::item_t   item,
  output spi_mrb_pkg::result_t res
);

  import spi_mrb_pkg::*;

  localparam logic [2:0] CS_LO = 3'(NUM_CS % 8);

  logic              srst_held_r, srst_held_nxt;
  logic [31:0]       scratch_r, scratch_nxt;
  logic [31:0]       int_en_r, int_en_nxt;
  logic              cmpl_r, cmpl_nxt;
  logic [4:0]        len_m1_r, len_m1_nxt;
  logic              extend_r, extend_nxt;
  logic [4:0]        sel_idx_r, sel_idx_nxt;
  timing_t           timing_r, timing_nxt;
  logic              mode_start_r, mode_start_nxt;
  logic              order_sel_r, order_sel_nxt;
  logic              tx_valid_r, tx_valid_nxt;
  logic [31:0]       tx_word_r, tx_word_nxt;
  logic              rx_valid_r, rx_valid_nxt;
  logic [31:0]       rx_word_r, rx_word_nxt;
  logic [NUM_CS-1:0] cs_r, cs_nxt;

  logic        wr_ok;
  logic [31:0] mosi_new;
  logic [31:0] rx_new;

  spi_mrb_order u_order (
    .order_sel  (order_sel_r),
    .len_m1     (item.wdata[20:16]),
    .tx_word    (tx_word_r),
    .miso       (item.miso),
    .mosi       (mosi_new),
    .rx_word    (rx_new)
  );

  assign wr_ok = (item.op == OP_WRITE) && (!srst_held_r || item.addr == ADDR_SRST);

  always_comb begin
    srst_held_nxt  = srst_held_r;
    scratch_nxt    = scratch_r;
    int_en_nxt     = int_en_r;
    cmpl_nxt       = cmpl_r;
    len_m1_nxt     = len_m1_r;
    extend_nxt     = extend_r;
    sel_idx_nxt    = sel_idx_r;
    timing_nxt     = timing_r;
    mode_start_nxt = mode_start_r;
    order_sel_nxt  = order_sel_r;
    tx_valid_nxt   = tx_valid_r;
    tx_word_nxt    = tx_word_r;
    rx_valid_nxt   = rx_valid_r;
    rx_word_nxt    = rx_word_r;
    cs_nxt         = cs_r;

    res            = '0;
    res.frame_bits = {1'b0, len_m1_r} + 6'd1;

    if (item.op == OP_READ) begin
      case (item.addr)
        ADDR_VERSION:   res.rdata = VERSION_WORD;
        ADDR_IPCFG:     res.rdata = {21'b0, CS_LO, 3'b0, NUM_BUF};
        ADDR_SRST:      res.rdata = {31'b0, srst_held_r};
        ADDR_SCRATCH:   res.rdata = scratch_r;
        ADDR_INT_STAT:  res.rdata = {31'b0, cmpl_r};
        ADDR_INT_EN:    res.rdata = int_en_r;
        ADDR_XFER_CTRL: res.rdata = {11'b0, len_m1_r, extend_r, 2'b0, sel_idx_r, 8'b0};
        ADDR_TIMING: begin
          res.rdata = {8'b0, timing_r.hold, timing_r.setup, 6'b0, timing_r.pha,
                       timing_r.pol, timing_r.div};
        end
        ADDR_MODE:      res.rdata = {23'b0, order_sel_r, 7'b0, mode_start_r};
        ADDR_RXDATA: begin
          if (rx_valid_r) begin
            res.rdata    = rx_word_r;
            rx_valid_nxt = 1'b0;
          end
        end
        default:        res.rdata = '0;
      endcase
    end else if (wr_ok) begin
      case (item.addr)
        ADDR_SRST: begin
          if (item.wdata[0]) begin
            // chip select lines keep their level
            srst_held_nxt  = 1'b1;
            scratch_nxt    = '0;
            int_en_nxt     = '0;
            cmpl_nxt       = 1'b0;
            len_m1_nxt     = '0;
            extend_nxt     = 1'b0;
            sel_idx_nxt    = '0;
            timing_nxt     = TIMING_RESET;
            mode_start_nxt = 1'b0;
            order_sel_nxt  = 1'b0;
            tx_valid_nxt   = 1'b0;
            rx_valid_nxt   = 1'b0;
          end else begin
            srst_held_nxt = 1'b0;
          end
        end
        ADDR_SCRATCH:  scratch_nxt = item.wdata;
        ADDR_INT_STAT: begin
          if (item.wdata[INT_COMPLETE]) begin
            cmpl_nxt = 1'b0;
          end
        end
        ADDR_INT_EN:   int_en_nxt = item.wdata;
        ADDR_XFER_CTRL: begin
          sel_idx_nxt    = item.wdata[12:8];
          extend_nxt     = item.wdata[15];
          len_m1_nxt     = item.wdata[20:16];
          res.frame_bits = {1'b0, item.wdata[20:16]} + 6'd1;
          if (item.wdata[CTRL_START]) begin
            // selected line ends low only when extended
            for (int i = 0; i < NUM_CS; i++) begin
              if (item.wdata[12:8] == 5'(i)) begin
                cs_nxt[i] = !item.wdata[15];
              end
            end
            if (tx_valid_r) begin
              res.xfer_valid = 1'b1;
              res.mosi       = mosi_new;
              tx_valid_nxt   = 1'b0;
              rx_valid_nxt   = 1'b1;
              rx_word_nxt    = rx_new;
            end
            cmpl_nxt = 1'b1;
          end
        end
        ADDR_TIMING: begin
          timing_nxt.div   = item.wdata[7:0];
          timing_nxt.pol   = item.wdata[8];
          timing_nxt.pha   = item.wdata[9];
          timing_nxt.setup = item.wdata[19:16];
          timing_nxt.hold  = item.wdata[23:20];
        end
        ADDR_MODE: begin
          mode_start_nxt = item.wdata[0];
          order_sel_nxt  = item.wdata[8];
        end
        ADDR_TXDATA: begin
          tx_word_nxt  = item.wdata;
          tx_valid_nxt = 1'b1;
        end
        default: ;
      endcase
    end

    res.irq                = cmpl_nxt & int_en_nxt[INT_COMPLETE];
    res.cs                 = '1;
    res.cs[NUM_CS-1:0]     = cs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srst_held_r  <= 1'b1;
      scratch_r    <= '0;
      int_en_r     <= '0;
      cmpl_r       <= 1'b0;
      len_m1_r     <= '0;
      extend_r     <= 1'b0;
      sel_idx_r    <= '0;
      timing_r     <= TIMING_RESET;
      mode_start_r <= 1'b0;
      order_sel_r  <= 1'b0;
      tx_valid_r   <= 1'b0;
      rx_valid_r   <= 1'b0;
      cs_r         <= '1;
    end else if (fire) begin
      srst_held_r  <= srst_held_nxt;
      scratch_r    <= scratch_nxt;
      int_en_r     <= int_en_nxt;
      cmpl_r       <= cmpl_nxt;
      len_m1_r     <= len_m1_nxt;
      extend_r     <= extend_nxt;
      sel_idx_r    <= sel_idx_nxt;
      timing_r     <= timing_nxt;
      mode_start_r <= mode_start_nxt;
      order_sel_r  <= order_sel_nxt;
      tx_valid_r   <= tx_valid_nxt;
      rx_valid_r   <= rx_valid_nxt;
      cs_r         <= cs_nxt;
    end
  end

  // holding words are only looked at while their valid bit is set
  always_ff @(posedge clk) begin
    if (fire) begin
      tx_word_r <= tx_word_nxt;
      rx_word_r <= rx_word_nxt;
    end
  end

endmodule

// File: rtl/spi_master_register_block_core.sv
// an accepted word waits in the input register and its result is loaded into the output register once that can load
// one register access per cycle while the result side is not stalled
// each access is registered at the input, decoded and applied in one pass, then registered
// rst_n is synchronous and active low: registers take their reset values, soft reset held,
// chip selects high, both holding registers empty, no word in flight
module spi_master_register_block_core #(
  parameter int NUM_CS = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [79:0]   in_tdata,   // address[11:0], write_data[43:12], miso_frame[75:44], zero
  input  logic          in_tuser,   // operation
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata   // read_data[31:0], irq[32], chip_selects[64:33],
                                    // transfer_valid[65], mosi_frame[97:66], frame_bits[103:98]
);

  import spi_mrb_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  item_t   in_item;
  logic    out_load;
  logic    fire;
  logic    in_accept;

  assign out_load  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && out_load;
  assign in_tready = !s1_valid_r || out_load;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_item.op    = op_t'(in_tuser);
    in_item.addr  = in_tdata[11:0];
    in_item.wdata = in_tdata[43:12];
    in_item.miso  = in_tdata[75:44];
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  spi_mrb_regs #(
    .NUM_CS (NUM_CS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

// File: rtl/spi_mrb_checker.sv
module spi_mrb_checker #(
  parameter int NUM_CS = 1
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // no frame shifted means no transmit bits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[65] |-> out_tdata[97:66] == 32'd0)
    else $error("mosi frame nonzero without a transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:98] != 6'd0 && out_tdata[103:98] <= 6'd32)
    else $error("frame length out of range");

  // lines beyond the implemented selects never drop
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[64:33] | ~(32'hFFFF_FFFF << NUM_CS)) == 32'hFFFF_FFFF)
    else $error("unimplemented chip select driven low");

  assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind spi_master_register_block_core spi_mrb_checker #(
  .NUM_CS (NUM_CS)
) u_spi_mrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb.sv
module tb;
  import spi_mrb_pkg::*;

  localparam int SEL_COUNT  = 1;
  localparam int SRST_BIT   = 0;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1650;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;   // address[11:0], write_data[43:12], miso_frame[75:44], zero
  logic         in_tuser = 1'b0; // operation
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // read_data[31:0], irq[32], chip_selects[64:33],
                                 // transfer_valid[65], mosi_frame[97:66], frame_bits[103:98]

  spi_master_register_block_core #(
    .NUM_CS(SEL_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register file as the block should hold it
  logic        srst_held;
  logic [31:0] scratch_word;
  logic [31:0] irq_mask_word;
  logic        complete_flag;
  logic [5:0]  frame_len;
  logic        sel_extend;
  logic [4:0]  sel_index;
  timing_t     timing;
  logic [1:0]  mode_bits;
  logic        tx_full;
  logic [31:0] tx_word;
  logic        rx_full;
  logic [31:0] rx_word;
  logic [31:0] sel_levels;

  result_t access_results[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;

  function automatic void clear_registers();
    srst_held     = 1'b1;
    scratch_word  = '0;
    irq_mask_word = '0;
    complete_flag = 1'b0;
    frame_len     = 6'd1;
    sel_extend    = 1'b0;
    sel_index     = '0;
    timing        = TIMING_RESET;
    mode_bits     = '0;
    tx_full       = 1'b0;
    tx_word       = '0;
    rx_full       = 1'b0;
    rx_word       = '0;
  endfunction

  // word bit carrying serial position t
  function automatic int word_bit(input int t);
    int fl;
    fl = frame_len;
    if (mode_bits[1]) return (fl - 1 - t) & 31;
    return ((t / 8) * 8 + 7 - (t % 8)) & 31;
  endfunction

  function automatic logic [31:0] word_to_frame(input logic [31:0] w);
    logic [31:0] f;
    int fl;
    f = '0;
    fl = frame_len;
    for (int t = 0; t < fl; t++) f[fl - 1 - t] = w[word_bit(t)];
    return f;
  endfunction

  function automatic logic [31:0] frame_to_word(input logic [31:0] f);
    logic [31:0] w;
    int fl;
    w = '0;
    fl = frame_len;
    for (int t = 0; t < fl; t++) w[word_bit(t)] = f[fl - 1 - t];
    return w;
  endfunction

  function automatic result_t predict_access(input op_t op, input logic [11:0] addr,
                                             input logic [31:0] wdata, input logic [31:0] miso);
    result_t res;
    logic    in_range;
    res = '0;
    res.frame_bits = frame_len;
    if (op == OP_READ) begin
      case (addr)
        ADDR_VERSION:   res.rdata = VERSION_WORD;
        ADDR_IPCFG: begin
          res.rdata[4:0]  = NUM_BUF;
          res.rdata[10:8] = 3'(SEL_COUNT);
        end
        ADDR_SRST:      res.rdata[0] = srst_held;
        ADDR_SCRATCH:   res.rdata = scratch_word;
        ADDR_INT_STAT:  res.rdata[0] = complete_flag;
        ADDR_INT_EN:    res.rdata = irq_mask_word;
        ADDR_XFER_CTRL: begin
          res.rdata[12:8]  = sel_index;
          res.rdata[15]    = sel_extend;
          res.rdata[20:16] = 5'(frame_len - 6'd1);
        end
        ADDR_TIMING:
          res.rdata = {8'h00, timing.hold, timing.setup, 6'b0, timing.pha, timing.pol,
                       timing.div};
        ADDR_MODE: begin
          res.rdata[0] = mode_bits[0];
          res.rdata[8] = mode_bits[1];
        end
        ADDR_RXDATA: begin
          // reading pops the holding register
          if (rx_full) begin
            res.rdata = rx_word;
            rx_full   = 1'b0;
            rx_word   = '0;
          end
        end
        default: ;
      endcase
    end else if (!srst_held || addr == ADDR_SRST) begin
      case (addr)
        ADDR_SRST: begin
          if (wdata[SRST_BIT]) clear_registers();
          else srst_held = 1'b0;
        end
        ADDR_SCRATCH:  scratch_word = wdata;
        ADDR_INT_STAT: if (wdata[INT_COMPLETE]) complete_flag = 1'b0;
        ADDR_INT_EN:   irq_mask_word = wdata;
        ADDR_XFER_CTRL: begin
          sel_index  = wdata[12:8];
          sel_extend = wdata[15];
          frame_len  = {1'b0, wdata[20:16]} + 6'd1;
          res.frame_bits = frame_len;
          if (wdata[CTRL_START]) begin
            in_range = (sel_index < SEL_COUNT);
            if (in_range) sel_levels[sel_index] = 1'b0;
            if (tx_full) begin
              res.mosi       = word_to_frame(tx_word);
              tx_full        = 1'b0;
              tx_word        = '0;
              rx_word        = frame_to_word(miso);
              rx_full        = 1'b1;
              res.xfer_valid = 1'b1;
            end
            if (!sel_extend && in_range) sel_levels[sel_index] = 1'b1;
            complete_flag = 1'b1;
          end
        end
        ADDR_TIMING: begin
          timing.div   = wdata[7:0];
          timing.pol   = wdata[8];
          timing.pha   = wdata[9];
          timing.setup = wdata[19:16];
          timing.hold  = wdata[23:20];
        end
        ADDR_MODE:   mode_bits = {wdata[8], wdata[0]};
        ADDR_TXDATA: begin
          tx_word = wdata;
          tx_full = 1'b1;
        end
        default: ;
      endcase
    end
    res.irq = complete_flag & irq_mask_word[0];
    res.cs  = sel_levels;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 50)
      $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task automatic check_reply(input result_t got, input result_t want);
    if (got.rdata !== want.rdata) report_mismatch("read_data", got.rdata, want.rdata);
    if (got.irq !== want.irq) report_mismatch("irq", 32'(got.irq), 32'(want.irq));
    if (got.cs !== want.cs) report_mismatch("chip_selects", got.cs, want.cs);
    if (got.xfer_valid !== want.xfer_valid)
      report_mismatch("transfer_valid", 32'(got.xfer_valid), 32'(want.xfer_valid));
    if (got.mosi !== want.mosi) report_mismatch("mosi_frame", got.mosi, want.mosi);
    if (got.frame_bits !== want.frame_bits)
      report_mismatch("frame_bits", 32'(got.frame_bits), 32'(want.frame_bits));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (access_results.size() == 0)
        report_mismatch("word with no access pending", out_tdata[31:0], '0);
      else
        check_reply(result_t'(out_tdata), access_results.pop_front());
    end
  end

  // result side stalls in segments: always ready, coin flip, one in three, rare stall
  int seg_left = 0;
  int seg_mode = 0;
  int pat_cnt  = 0;

  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_mode <= $urandom_range(0, 3);
      seg_left <= $urandom_range(20, 200);
    end else begin
      seg_left <= seg_left - 1;
    end
    pat_cnt <= pat_cnt + 1;
    case (seg_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (pat_cnt % 3 == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_access(input op_t op, input logic [11:0] addr,
                             input logic [31:0] wdata, input logic [31:0] miso);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, miso, wdata, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    access_results.push_back(predict_access(op, addr, wdata, miso));
    items_sent++;
  endtask

  task automatic wr(input logic [11:0] addr, input logic [31:0] data);
    send_access(OP_WRITE, addr, data, $urandom);
  endtask

  task automatic rd(input logic [11:0] addr);
    send_access(OP_READ, addr, $urandom, $urandom);
  endtask

  function automatic logic [11:0] pick_mapped();
    case ($urandom_range(0, 10))
      0:       return ADDR_VERSION;
      1:       return ADDR_IPCFG;
      2:       return ADDR_SRST;
      3:       return ADDR_SCRATCH;
      4:       return ADDR_INT_STAT;
      5:       return ADDR_INT_EN;
      6:       return ADDR_XFER_CTRL;
      7:       return ADDR_TIMING;
      8:       return ADDR_MODE;
      9:       return ADDR_TXDATA;
      default: return ADDR_RXDATA;
    endcase
  endfunction

  task automatic test_reset_state();
    rd(ADDR_VERSION);
    rd(ADDR_IPCFG);
    rd(ADDR_SRST);
    rd(ADDR_XFER_CTRL);
    rd(ADDR_TIMING);
    rd(ADDR_RXDATA);
  endtask

  // writes bounce off while soft reset is held
  task automatic test_soft_reset_hold();
    wr(ADDR_SCRATCH, 32'hFFFF_FFFF);
    rd(ADDR_SCRATCH);
    wr(ADDR_SRST, 32'h0);
  endtask

  task automatic test_register_access();
    wr(ADDR_SCRATCH, 32'hFFFF_FFFF);
    rd(ADDR_SCRATCH);
    wr(ADDR_INT_EN, 32'hFFFF_FFFF);
    wr(ADDR_TIMING, 32'hFFFF_FFFF);
    rd(ADDR_TIMING);
    wr(ADDR_MODE, 32'hFFFF_FFFF);
    rd(ADDR_MODE);
    wr(12'hFFF, 32'hFFFF_FFFF);
    rd(12'h01D);
  endtask

  task automatic test_frame_transfers();
    // full 32-bit frame, low-bits order, select held low afterwards
    wr(ADDR_TXDATA, 32'h8000_0001);
    send_access(OP_WRITE, ADDR_XFER_CTRL, 32'h001F_8001, 32'hFFFF_FFFF);
    rd(ADDR_RXDATA);
    rd(ADDR_RXDATA);
    // one-bit frame, msb-first byte order, select released
    wr(ADDR_MODE, 32'h0);
    wr(ADDR_TXDATA, 32'h0000_00A5);
    send_access(OP_WRITE, ADDR_XFER_CTRL, 32'h0000_0001, 32'h0);
    // empty transmit word and a select past the last line
    send_access(OP_WRITE, ADDR_XFER_CTRL, 32'h0007_1F01, 32'h5A5A_5A5A);
    wr(ADDR_INT_STAT, 32'h1);
    rd(ADDR_INT_STAT);
  endtask

  task automatic test_soft_reset_clear();
    wr(ADDR_TXDATA, 32'h1234_5678);
    wr(ADDR_SRST, 32'h1);
    rd(ADDR_SCRATCH);
    wr(ADDR_SRST, 32'h0);
  endtask

  task automatic test_random_traffic(input int count);
    int          stop_at;
    int          pick;
    logic [31:0] data;
    logic [11:0] addr;
    op_t         op;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // mostly complete transfers: release, mode, load, start, drain
        if (srst_held && $urandom_range(0, 3) != 0) wr(ADDR_SRST, $urandom & 32'hFFFF_FFFE);
        if ($urandom_range(0, 3) == 0) wr(ADDR_MODE, $urandom);
        if ($urandom_range(0, 7) != 0) wr(ADDR_TXDATA, $urandom);
        data = $urandom;
        data[CTRL_START] = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 1) == 0) data[12:8] = '0;
        send_access(OP_WRITE, ADDR_XFER_CTRL, data, $urandom);
        if ($urandom_range(0, 9) < 7) rd(ADDR_RXDATA);
      end else if (pick < 80) begin
        addr = pick_mapped();
        op   = op_t'($urandom_range(0, 1));
        data = $urandom;
        if (addr == ADDR_SRST && op == OP_WRITE) data[SRST_BIT] = ($urandom_range(0, 7) == 0);
        send_access(op, addr, data, $urandom);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0:       wr(ADDR_INT_STAT, $urandom);
          1:       wr(ADDR_INT_EN, $urandom);
          2:       rd(ADDR_INT_STAT);
          default: rd(ADDR_INT_EN);
        endcase
      end else begin
        send_access(op_t'($urandom_range(0, 1)), 12'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    clear_registers();
    sel_levels = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_soft_reset_hold();
    test_register_access();
    test_frame_transfers();
    test_soft_reset_clear();
    test_random_traffic(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    while (access_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
